// File: sv/vscp_pkg.sv
// Shared types and constants of the voice start command packer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package vscp_pkg;

    // Field widths and sizes.
    localparam int SLOT_COUNT          = 20;
    localparam int SLOT_W              = 5;
    localparam int VOICE_W             = 9;
    localparam int GEN_W               = 16;
    localparam int WORD_W              = 32;
    localparam int VOICE_COUNT_DEFAULT = 512;
    localparam int QUEUE_DEPTH         = 2;
    localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS           = 32;
    localparam int DIV_CNT_W           = $clog2(DIV_STEPS + 1);

    // Command constants.
    localparam logic [7:0]  OPCODE_START    = 8'h10;
    localparam logic [31:0] SECOND_FLAG_BIT = 32'h0001_0000;
    localparam logic [31:0] SUSTAIN_FULL    = 32'd1000;
    localparam logic [31:0] RELEASE_NUM     = SUSTAIN_FULL << 20;
    localparam logic [31:0] ATTACK_NUM      = 32'hFFFF_FFFF;
    localparam logic [4:0]  BASE_PAYLOAD    = 5'd5;
    localparam logic [4:0]  LOOP_PAYLOAD    = 5'd2;
    localparam logic [4:0]  FILT_PAYLOAD    = 5'd3;
    localparam logic [4:0]  ENV_PAYLOAD     = 5'd6;

    // Parameter slot indexes.
    localparam logic [4:0] S_ADDR    = 5'd0;
    localparam logic [4:0] S_LEN     = 5'd1;
    localparam logic [4:0] S_LSTART  = 5'd2;
    localparam logic [4:0] S_LEND    = 5'd3;
    localparam logic [4:0] S_LMODE   = 5'd4;
    localparam logic [4:0] S_PHASE   = 5'd5;
    localparam logic [4:0] S_GAIN_L  = 5'd6;
    localparam logic [4:0] S_GAIN_R  = 5'd7;
    localparam logic [4:0] S_FEN     = 5'd8;
    localparam logic [4:0] S_B0      = 5'd9;
    localparam logic [4:0] S_B1      = 5'd10;
    localparam logic [4:0] S_B2      = 5'd11;
    localparam logic [4:0] S_A1      = 5'd12;
    localparam logic [4:0] S_A2      = 5'd13;
    localparam logic [4:0] S_DELAY   = 5'd14;
    localparam logic [4:0] S_ATTACK  = 5'd15;
    localparam logic [4:0] S_HOLD    = 5'd16;
    localparam logic [4:0] S_DECAY   = 5'd17;
    localparam logic [4:0] S_SUSTAIN = 5'd18;
    localparam logic [4:0] S_RELEASE = 5'd19;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic               is_start;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  value;
        logic [VOICE_W-1:0] voice;
        logic [GEN_W-1:0]   generation;
    } vscp_item_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } vscp_div_req_t;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] quotient;
    } vscp_div_rsp_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } vscp_state_t;

    // Command word kinds in emission order.
    typedef enum logic [4:0] {
        W_HDR, W_GEN, W_ADDR, W_LEN, W_LSTART, W_LEND, W_PHASE, W_GAIN,
        W_F0, W_F1, W_F2, W_DELAY, W_ATK, W_HOLD, W_DEC, W_SUS, W_REL
    } vscp_word_t;

    // Envelope rates computed by the divider.
    typedef enum logic [1:0] {
        RATE_ATTACK,
        RATE_DECAY,
        RATE_RELEASE
    } vscp_rate_t;

endpackage

`default_nettype wire

// File: sv/vscp_front.sv
// Front end: unpacks input transfers, drops ignored items, pushes the rest.
// Depends on vscp_pkg.
`default_nettype none

module vscp_front
    import vscp_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEFAULT
) (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        q_full,
    output logic             q_push,
    output vscp_item_t       q_item
);

    logic slot_ok;
    logic voice_ok;
    logic keep;

    // Unpack the fields from the stream word.
    always_comb begin
        q_item.is_start   = s_tuser;
        q_item.slot       = s_tdata[4:0];
        q_item.value      = s_tdata[36:5];
        q_item.voice      = s_tdata[45:37];
        q_item.generation = s_tdata[61:46];
    end

    // Loads to unused slots and starts for absent voices are dropped here.
    assign slot_ok  = q_item.slot < SLOT_W'(SLOT_COUNT);
    assign voice_ok = {23'd0, q_item.voice} < 32'(VOICE_COUNT);
    assign keep     = q_item.is_start ? voice_ok : slot_ok;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule

`default_nettype wire

// File: sv/vscp_queue.sv
// Short queue between the front end and the back end.
// Depends on vscp_pkg.
`default_nettype none

module vscp_queue
    import vscp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire vscp_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output vscp_item_t      head,
    output logic            empty
);

    vscp_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full    = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/vscp_divider.sv
// Bit-serial restoring divider giving a saturated ceiling quotient.
// One quotient bit per cycle; a zero divisor gives zero. Depends on vscp_pkg.
`default_nettype none

module vscp_divider
    import vscp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire vscp_div_req_t req,
    output vscp_div_rsp_t      rsp
);

    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    quo_reg;
    logic [WORD_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic [WORD_W:0]      rounded;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // One restoring step per cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (cnt_reg != '0) begin
            if (!diff[WORD_W]) begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    // Round up on a nonzero remainder and saturate.
    assign rounded = {1'b0, quo_reg} + (WORD_W + 1)'(rem_reg != '0);

    always_comb begin
        rsp.busy = cnt_reg != '0;
        if (den_reg == '0) begin
            rsp.quotient = '0;
        end else if (rounded[WORD_W]) begin
            rsp.quotient = '1;
        end else begin
            rsp.quotient = rounded[WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/vscp_back.sv
// Back end: parameter store, envelope rate sequencing and command emission.
// Depends on vscp_pkg and drives the divider through its request struct.
`default_nettype none

module vscp_back
    import vscp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire vscp_item_t    head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output vscp_div_req_t      div_req,
    input  wire vscp_div_rsp_t div_rsp,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast
);

    logic [WORD_W-1:0]  store_reg [SLOT_COUNT];
    logic [WORD_W-1:0]  rate_reg [3];
    vscp_state_t        state_reg;
    vscp_state_t        state_next;
    vscp_rate_t         rate_idx_reg;
    vscp_word_t         kind_reg;
    vscp_word_t         kind_next;
    logic [VOICE_W-1:0] voice_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_data_reg;
    logic               out_last_reg;

    logic               store_we;
    logic               start_take;
    logic               rate_capture;
    logic               emit_fire;
    logic [7:0]         mode;
    logic               loop_en;
    logic               filt_en;
    logic               env_en;
    logic [3:0]         flags;
    logic [4:0]         payload;
    logic [WORD_W-1:0]  header;
    logic [WORD_W-1:0]  word;
    logic               word_last;

    // Command shape from the stored parameters.
    assign mode    = store_reg[S_LMODE][7:0];
    assign loop_en = mode != '0;
    assign filt_en = store_reg[S_FEN][7:0] != '0;
    assign env_en  = (store_reg[S_DELAY] != '0) || (store_reg[S_ATTACK] != '0) ||
                     (store_reg[S_HOLD] != '0) || (store_reg[S_DECAY] != '0) ||
                     (store_reg[S_SUSTAIN] != '0) || (store_reg[S_RELEASE] != '0);
    assign flags   = {env_en, filt_en, mode[1:0]};
    assign payload = BASE_PAYLOAD + (loop_en ? LOOP_PAYLOAD : 5'd0)
                   + (filt_en ? FILT_PAYLOAD : 5'd0) + (env_en ? ENV_PAYLOAD : 5'd0);
    assign header  = {OPCODE_START, 1'b0, voice_reg, 2'b00, flags, 3'b000, payload};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && head.is_start) begin
                    state_next = env_en ? ST_DIV_START : ST_EMIT;
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!div_rsp.busy) begin
                    state_next = (rate_idx_reg == RATE_RELEASE) ? ST_EMIT : ST_DIV_START;
                end
            end
            ST_EMIT: begin
                if (emit_fire && word_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        q_pop        = (state_reg == ST_IDLE) && !q_empty;
        store_we     = q_pop && !head.is_start;
        start_take   = q_pop && head.is_start;
        rate_capture = (state_reg == ST_DIV_WAIT) && !div_rsp.busy;
        emit_fire    = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    end

    // Divider operands for the rate in progress.
    always_comb begin
        div_req.start = state_reg == ST_DIV_START;
        case (rate_idx_reg)
            RATE_ATTACK: begin
                div_req.num = ATTACK_NUM;
                div_req.den = store_reg[S_ATTACK];
            end
            RATE_DECAY: begin
                div_req.num = store_reg[S_SUSTAIN];
                div_req.den = store_reg[S_DECAY];
            end
            default: begin
                div_req.num = RELEASE_NUM;
                div_req.den = store_reg[S_RELEASE];
            end
        endcase
    end

    // Word order, skipping the groups that are not enabled.
    always_comb begin
        kind_next = W_HDR;
        unique case (kind_reg)
            W_HDR:    kind_next = W_GEN;
            W_GEN:    kind_next = W_ADDR;
            W_ADDR:   kind_next = W_LEN;
            W_LEN:    kind_next = loop_en ? W_LSTART : W_PHASE;
            W_LSTART: kind_next = W_LEND;
            W_LEND:   kind_next = W_PHASE;
            W_PHASE:  kind_next = W_GAIN;
            W_GAIN:   kind_next = filt_en ? W_F0 : W_DELAY;
            W_F0:     kind_next = W_F1;
            W_F1:     kind_next = W_F2;
            W_F2:     kind_next = W_DELAY;
            W_DELAY:  kind_next = W_ATK;
            W_ATK:    kind_next = W_HOLD;
            W_HOLD:   kind_next = W_DEC;
            W_DEC:    kind_next = W_SUS;
            W_SUS:    kind_next = W_REL;
            W_REL:    kind_next = W_HDR;
            default:  kind_next = W_HDR;
        endcase
    end

    // The last word depends on which optional groups follow.
    assign word_last = ((kind_reg == W_GAIN) && !filt_en && !env_en) ||
                       ((kind_reg == W_F2) && !env_en) || (kind_reg == W_REL);

    // Word contents.
    always_comb begin
        case (kind_reg)
            W_HDR:    word = header;
            W_GEN:    word = {16'd0, gen_reg};
            W_ADDR:   word = store_reg[S_ADDR];
            W_LEN:    word = store_reg[S_LEN];
            W_LSTART: word = store_reg[S_LSTART];
            W_LEND:   word = store_reg[S_LEND];
            W_PHASE:  word = store_reg[S_PHASE];
            W_GAIN:   word = {store_reg[S_GAIN_R][15:0], store_reg[S_GAIN_L][15:0]};
            W_F0:     word = {store_reg[S_B1][15:0], store_reg[S_B0][15:0]};
            W_F1:     word = {store_reg[S_A1][15:0], store_reg[S_B2][15:0]};
            W_F2:     word = {16'd0, store_reg[S_A2][15:0]} | SECOND_FLAG_BIT;
            W_DELAY:  word = store_reg[S_DELAY];
            W_ATK:    word = rate_reg[RATE_ATTACK];
            W_HOLD:   word = store_reg[S_HOLD];
            W_DEC:    word = rate_reg[RATE_DECAY];
            W_SUS:    word = store_reg[S_SUSTAIN];
            W_REL:    word = rate_reg[RATE_RELEASE];
            default:  word = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rate_idx_reg  <= RATE_ATTACK;
            kind_reg      <= W_HDR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start_take) begin
                rate_idx_reg <= RATE_ATTACK;
                kind_reg     <= W_HDR;
            end else begin
                if (rate_capture) begin
                    rate_idx_reg <= vscp_rate_t'(rate_idx_reg + 2'd1);
                end
                if (emit_fire) begin
                    kind_reg <= kind_next;
                end
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Parameter store, cleared to zero at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                store_reg[i] <= '0;
            end
        end else if (store_we) begin
            store_reg[head.slot] <= head.value;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (start_take) begin
            voice_reg <= head.voice;
            gen_reg   <= head.generation;
        end
        if (rate_capture) begin
            rate_reg[rate_idx_reg] <= div_rsp.quotient;
        end
        if (emit_fire) begin
            out_data_reg <= word;
            out_last_reg <= word_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // The divider is never restarted while it is still working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Loading the final word of a command returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && word_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not finish after the final word");

    // Rate words are emitted only for commands that carry an envelope.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (kind_reg == W_ATK)) |-> env_en)
        else $error("envelope word emitted without envelope");
`endif

endmodule

`default_nettype wire

// File: sv/voice_start_command_packer_unit.sv
// Voice start command packer: top level joining front end, queue, divider and back end.
// Depends on vscp_pkg, vscp_front, vscp_queue, vscp_divider and vscp_back.
//
// Load items (tuser low) write one of twenty parameter slots; start items
// (tuser high) emit a command of 6 to 17 words on the master stream, the
// last one marked by tlast. Load and start items ignored by the command
// rules are dropped by the front end. A two-entry queue decouples input from
// the back end, so up to two items are absorbed while a command is still
// being sent. A start leaves the queue; without an envelope its 6 to 11
// command words are then sent. With an envelope, the shared bit-serial
// divider first computes the three rates in turn, followed by the 12 to 17
// command words. Output stalls delay the emission.
`default_nettype none

module voice_start_command_packer_unit
    import vscp_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: slot [4:0], value [36:5], voice [45:37], generation [61:46], zero above.
    input  wire logic [63:0] s_tdata,
    // s_tuser: operation (0 load, 1 start).
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: command_word [31:0].
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    vscp_item_t    push_item;
    vscp_item_t    head;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    vscp_div_req_t div_req;
    vscp_div_rsp_t div_rsp;

    // Classification of incoming transfers.
    vscp_front #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Decoupling queue.
    vscp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Shared rate divider.
    vscp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Parameter store and command emission.
    vscp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: tb/start_command_checker.sv
// Checker for the voice start command packer: follows the input stream, predicts
// every command word and compares it with the master stream.
// Depends on vscp_pkg for slot indexes and command constants.

module start_command_checker
    import vscp_pkg::*;
#(
    parameter int VOICE_LIMIT = VOICE_COUNT_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // s_tdata: slot [4:0], value [36:5], voice [45:37], generation [61:46], zero above.
    input  wire logic [63:0] s_tdata,
    // s_tuser: operation (0 load, 1 start).
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: command_word [31:0].
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    output int               mismatch_count,
    output int               words_outstanding
);

    // One predicted command word and its end-of-command mark.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } command_beat_t;

    command_beat_t pending_words [$];
    logic [31:0]   note_params [SLOT_COUNT];
    command_beat_t oldest;

    // Ceiling division for the envelope rates; a zero divisor gives zero.
    function automatic logic [31:0] ceil_rate(input logic [63:0] num, input logic [31:0] den);
        logic [63:0] q;
        if (den == '0) begin
            return '0;
        end
        q = (num + 64'(den) - 64'd1) / 64'(den);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Build the whole command for one start and queue its words.
    function automatic void predict_start_command(input logic [8:0] voice,
                                                  input logic [15:0] gen);
        logic [31:0] words [$];
        logic [7:0]  mode;
        logic        loop_on;
        logic        filt_on;
        logic        env_on;
        logic [3:0]  flags;
        logic [4:0]  payload;
        mode    = note_params[S_LMODE][7:0];
        loop_on = (mode != '0);
        filt_on = (note_params[S_FEN][7:0] != '0);
        env_on  = (note_params[S_DELAY] != '0) || (note_params[S_ATTACK] != '0) ||
                  (note_params[S_HOLD] != '0) || (note_params[S_DECAY] != '0) ||
                  (note_params[S_SUSTAIN] != '0) || (note_params[S_RELEASE] != '0);
        flags   = {env_on, filt_on, mode[1:0]};
        payload = BASE_PAYLOAD + (loop_on ? LOOP_PAYLOAD : 5'd0) +
                  (filt_on ? FILT_PAYLOAD : 5'd0) + (env_on ? ENV_PAYLOAD : 5'd0);

        words.push_back({OPCODE_START, 1'b0, voice, 2'b00, flags, 3'b000, payload});
        words.push_back({16'd0, gen});
        words.push_back(note_params[S_ADDR]);
        words.push_back(note_params[S_LEN]);
        if (loop_on) begin
            words.push_back(note_params[S_LSTART]);
            words.push_back(note_params[S_LEND]);
        end
        words.push_back(note_params[S_PHASE]);
        words.push_back({note_params[S_GAIN_R][15:0], note_params[S_GAIN_L][15:0]});
        if (filt_on) begin
            words.push_back({note_params[S_B1][15:0], note_params[S_B0][15:0]});
            words.push_back({note_params[S_A1][15:0], note_params[S_B2][15:0]});
            words.push_back({16'd0, note_params[S_A2][15:0]} | SECOND_FLAG_BIT);
        end
        if (env_on) begin
            words.push_back(note_params[S_DELAY]);
            words.push_back(ceil_rate(64'(ATTACK_NUM), note_params[S_ATTACK]));
            words.push_back(note_params[S_HOLD]);
            words.push_back(ceil_rate(64'(note_params[S_SUSTAIN]), note_params[S_DECAY]));
            words.push_back(note_params[S_SUSTAIN]);
            words.push_back(ceil_rate(64'(RELEASE_NUM), note_params[S_RELEASE]));
        end
        foreach (words[k]) begin
            pending_words.push_back('{word: words[k], last: (k == words.size() - 1)});
        end
    endfunction

    // Compare each output transfer with the oldest prediction, then follow the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (note_params[i]) begin
                note_params[i] = '0;
            end
            pending_words.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_words.size() == 0) begin
                    $error("command_word unexpected: expected none, actual %h", m_tdata);
                    mismatch_count++;
                end else begin
                    oldest = pending_words.pop_front();
                    if (m_tdata !== oldest.word) begin
                        $error("command_word mismatch: expected %h, actual %h",
                               oldest.word, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $error("last_word mismatch: expected %b, actual %b",
                               oldest.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    if (int'(s_tdata[45:37]) < VOICE_LIMIT) begin
                        predict_start_command(s_tdata[45:37], s_tdata[61:46]);
                    end
                end else if (int'(s_tdata[4:0]) < SLOT_COUNT) begin
                    note_params[s_tdata[4:0]] = s_tdata[36:5];
                end
            end
        end
        words_outstanding = pending_words.size();
    end

endmodule

// File: tb/tb_voice_start_command_packer_unit.sv
// Testbench top for the voice start command packer: drives load and start
// transfers with random gaps and stalls, and reports the checker's verdict.
// Depends on vscp_pkg, voice_start_command_packer_unit and start_command_checker.

module tb_voice_start_command_packer_unit;
    import vscp_pkg::*;

    localparam logic OP_LOAD         = 1'b0;
    localparam logic OP_START        = 1'b1;
    localparam int   TARGET_ITEMS    = 260;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   SETTLE_CYCLES   = 200;
    localparam int   IDLE_LIMIT      = 5000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int mismatch_count;
    int words_outstanding;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    voice_start_command_packer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    start_command_checker word_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one item after a random gap and hold it until the transfer happens.
    task automatic send_item(input logic op, input logic [4:0] slot, input logic [31:0] value,
                             input logic [8:0] voice, input logic [15:0] gen);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, gen, voice, value, slot};
        do @(posedge aclk); while (!s_tready);
        // Loads to slots past the store are dropped by the block.
        if (op == OP_START || int'(slot) < SLOT_COUNT) begin
            items_sent++;
        end
    endtask

    task automatic load_slot(input logic [4:0] slot, input logic [31:0] value);
        send_item(OP_LOAD, slot, value, 9'($urandom), 16'($urandom));
    endtask

    task automatic start_note(input logic [8:0] voice, input logic [15:0] gen);
        send_item(OP_START, 5'($urandom), $urandom, voice, gen);
    endtask

    // Stop offering items until every predicted word has come out.
    task automatic wait_for_commands();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (words_outstanding != 0);
        @(posedge aclk);
    endtask

    // Mostly real slots, now and then one past the store.
    function automatic logic [4:0] pick_slot();
        if ($urandom_range(0, 7) == 0) begin
            return 5'($urandom_range(SLOT_COUNT, 31));
        end
        return 5'($urandom_range(0, SLOT_COUNT - 1));
    endfunction

    // Values weighted toward zero, all ones, tiny and single-bit cases.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 3));
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls per transfer, with two long hold-offs.
    initial begin
        int gap;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken == 30 || taken == 200) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        int loads;
        bit paused;
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, then loop, filter and envelope words switched on.
        start_note(9'd0, 16'd0);
        load_slot(S_ADDR, 32'hFFFF_FFFF);
        load_slot(S_LEN, 32'd0);
        load_slot(S_GAIN_L, 32'hFFFF_FFFF);
        load_slot(S_GAIN_R, 32'h1234_8001);
        // Mode and enable only look at their low byte.
        load_slot(S_LMODE, 32'h0000_0100);
        load_slot(S_FEN, 32'h0000_0200);
        start_note(9'h1FF, 16'hFFFF);
        load_slot(S_LMODE, 32'h0000_0082);
        load_slot(S_LSTART, 32'hFFFF_FFFF);
        load_slot(S_LEND, 32'd1);
        load_slot(S_FEN, 32'h0000_00FF);
        load_slot(S_B0, 32'hFFFF_0001);
        load_slot(S_A2, 32'h0000_FFFF);
        // Envelope on through the delay alone, so all three divisors are zero.
        load_slot(S_DELAY, 32'd1);
        start_note(9'h155, 16'h8000);
        load_slot(S_ATTACK, 32'd1);
        load_slot(S_DECAY, 32'd1);
        load_slot(S_SUSTAIN, 32'hFFFF_FFFF);
        load_slot(S_RELEASE, 32'hFFFF_FFFF);
        // Slots past the store must leave the command unchanged.
        load_slot(5'd20, 32'hDEAD_BEEF);
        load_slot(5'd31, 32'hFFFF_FFFF);
        start_note(9'h0AA, 16'h00FF);
        wait_for_commands();

        // Random notes: a handful of loads then a start, with some noise.
        while (items_sent < TARGET_ITEMS) begin
            no_idle = (items_sent >= 120 && items_sent < 165);
            if (!paused && items_sent >= 180) begin
                paused = 1'b1;
                wait_for_commands();
            end
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 1) == 0) begin
                        load_slot(5'($urandom), $urandom);
                    end else begin
                        start_note(9'($urandom), 16'($urandom));
                    end
                end
                1: begin
                    // Clear the envelope so shorter commands show up again.
                    for (int s = int'(S_DELAY); s <= int'(S_RELEASE); s++) begin
                        load_slot(5'(s), '0);
                    end
                    start_note(9'($urandom), 16'($urandom));
                end
                default: begin
                    loads = $urandom_range(0, 6);
                    repeat (loads) load_slot(pick_slot(), pick_value());
                    start_note(9'($urandom), 16'($urandom));
                end
            endcase
        end
        no_idle = 1'b0;

        wait_for_commands();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
sv/vscp_pkg.sv
sv/vscp_front.sv
sv/vscp_queue.sv
sv/vscp_divider.sv
sv/vscp_back.sv
sv/voice_start_command_packer_unit.sv
tb/start_command_checker.sv
tb/tb_voice_start_command_packer_unit.sv
